// ===== hw/rtl/asd_pkg.sv =====
// ----------------------------------------------------------------------------
// Accelerometer step detector package
// Shared widths, codes and transaction types of the step detector.
// ----------------------------------------------------------------------------
package asd_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int ACCEL_W     = 16;
	localparam int SQ_W        = 2 * SAMPLE_BITS;
	localparam int SUM_W       = SQ_W + 2;
	localparam int THR_W       = 32;
	localparam int CMP_W       = (SUM_W > THR_W) ? SUM_W : THR_W;
	localparam int TIME_W      = 32;
	localparam int INTV_W      = 16;
	localparam int CNT_W       = 32;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SQ    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL_MS = 8'd1;

	localparam logic [THR_W-1:0]  THRESHOLD_SQ_RESET    = 32'd21050000;
	localparam logic [INTV_W-1:0] MIN_INTERVAL_MS_RESET = 16'd300;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef struct packed {
		logic              op;
		logic [TIME_W-1:0] time_ms;
	} item_ctl_t;

	typedef struct packed {
		logic              op;
		logic              above;
		logic [TIME_W-1:0] time_ms;
	} step_req_t;

endpackage

// ===== hw/rtl/asd_square_lane.sv =====
// ----------------------------------------------------------------------------
// Square lane
// Squares one signed axis sample taken at SAMPLE_BITS bits and registers it.
// ----------------------------------------------------------------------------
module asd_square_lane import asd_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [ACCEL_W-1:0] sample,
	output logic [SQ_W-1:0]           sq_s1
);

	logic [SAMPLE_BITS+ACCEL_W-1:0] ext;
	logic [SAMPLE_BITS-1:0]         v;
	logic [SAMPLE_BITS-1:0]         neg;
	logic [SAMPLE_BITS-1:0]         mag;
	logic [SQ_W-1:0]                prod;

	always_comb begin
		ext  = {{SAMPLE_BITS{1'b0}}, sample};
		v    = ext[SAMPLE_BITS-1:0];
		neg  = ~v + {{(SAMPLE_BITS-1){1'b0}}, 1'b1};
		mag  = v[SAMPLE_BITS-1] ? neg : v;
		prod = SQ_W'(mag) * SQ_W'(mag);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= prod;
		end
	end

endmodule

// ===== hw/rtl/asd_merge.sv =====
// ----------------------------------------------------------------------------
// Lane merge
// Sums the three squared axes and compares the magnitude with the threshold.
// ----------------------------------------------------------------------------
module asd_merge import asd_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [SQ_W-1:0]  sq_x_s1,
	input  logic [SQ_W-1:0]  sq_y_s1,
	input  logic [SQ_W-1:0]  sq_z_s1,
	input  item_ctl_t        ctl_s1,
	input  logic [THR_W-1:0] threshold_sq,
	output step_req_t        req_s2
);

	logic [CMP_W-1:0] mag_sq;
	logic             above;

	always_comb begin
		mag_sq = CMP_W'(sq_x_s1) + CMP_W'(sq_y_s1) + CMP_W'(sq_z_s1);
		above  = mag_sq >= CMP_W'(threshold_sq);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s2.op      <= ctl_s1.op;
			req_s2.above   <= above;
			req_s2.time_ms <= ctl_s1.time_ms;
		end
	end

endmodule

// ===== hw/rtl/asd_step_ctrl.sv =====
// ----------------------------------------------------------------------------
// Step control
// Holds the crossing state, the last step time and the step total.
// ----------------------------------------------------------------------------
module asd_step_ctrl import asd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  step_req_t         req_s2,
	input  logic [INTV_W-1:0] min_interval_ms,
	output logic              detected_q,
	output logic [CNT_W-1:0]  total_q
);

	logic              prev_below_q;
	logic [TIME_W-1:0] last_step_time_q;
	logic [TIME_W-1:0] elapsed;
	logic              count_step;

	always_comb begin
		elapsed    = req_s2.time_ms - last_step_time_q;
		count_step = prev_below_q && req_s2.above
			&& (elapsed >= TIME_W'(min_interval_ms));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_below_q     <= 1'b1;
			last_step_time_q <= '0;
			total_q          <= '0;
			detected_q       <= 1'b0;
		end else if (load) begin
			if (req_s2.op == OP_CLEAR) begin
				total_q    <= '0;
				detected_q <= 1'b0;
			end else begin
				prev_below_q <= !req_s2.above;
				detected_q   <= count_step;
				if (count_step) begin
					total_q          <= total_q + CNT_W'(1);
					last_step_time_q <= req_s2.time_ms;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/accel_step_detector.sv =====
// ----------------------------------------------------------------------------
// Accelerometer step detector
// Counts steps as upward threshold crossings of the squared acceleration.
// ----------------------------------------------------------------------------
// Each input transaction carries an op, three signed axis samples and a
// millisecond timestamp. A sample op squares the axes in three parallel
// lanes, sums them and compares the sum with threshold_sq. A rise from below
// to at or above the threshold counts a step if at least min_interval_ms has
// passed since the last counted step. A clear op zeroes the step count.
// Every input transaction yields exactly one output transaction with
// step_detected and step_count.
// The pipeline has three register stages: the squared axes, the merged
// compare result and the step control outputs. One transaction per cycle
// is sustained while the receiver does not stall. When the receiver stalls,
// results stay in the output register and the earlier stages keep filling,
// so input is accepted until all three stages hold a transaction.
// Configuration writes are always accepted.
// After reset the registers hold their default values, the count and last
// step time are zero and the previous sample counts as below threshold.
// ----------------------------------------------------------------------------
module accel_step_detector import asd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      op,
	input  logic signed [ACCEL_W-1:0] accel_x,
	input  logic signed [ACCEL_W-1:0] accel_y,
	input  logic signed [ACCEL_W-1:0] accel_z,
	input  logic [TIME_W-1:0]         time_ms,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      step_detected,
	output logic [CNT_W-1:0]          step_count,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	logic [THR_W-1:0]  threshold_sq_q;
	logic [INTV_W-1:0] min_interval_ms_q;
	logic              valid_s1;
	logic              valid_s2;
	logic              out_valid_q;
	logic              adv_out;
	logic              en_s2;
	logic              en_s1;
	logic              load_out;
	item_ctl_t         ctl_s1;
	step_req_t         req_s2;
	logic [SQ_W-1:0]   sq_x_s1;
	logic [SQ_W-1:0]   sq_y_s1;
	logic [SQ_W-1:0]   sq_z_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_sq_q    <= THRESHOLD_SQ_RESET;
			min_interval_ms_q <= MIN_INTERVAL_MS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THRESHOLD_SQ: begin
					threshold_sq_q <= cfg_data[THR_W-1:0];
				end
				REG_MIN_INTERVAL_MS: begin
					min_interval_ms_q <= cfg_data[INTV_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		adv_out  = !out_valid_q || out_ready;
		en_s2    = !valid_s2 || adv_out;
		en_s1    = !valid_s1 || en_s2;
		load_out = valid_s2 && adv_out;
		in_ready = en_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ctl_s1.op      <= op;
			ctl_s1.time_ms <= time_ms;
		end
	end

	asd_square_lane u_lane_x (
		.clk    (clk),
		.en     (en_s1),
		.sample (accel_x),
		.sq_s1  (sq_x_s1)
	);

	asd_square_lane u_lane_y (
		.clk    (clk),
		.en     (en_s1),
		.sample (accel_y),
		.sq_s1  (sq_y_s1)
	);

	asd_square_lane u_lane_z (
		.clk    (clk),
		.en     (en_s1),
		.sample (accel_z),
		.sq_s1  (sq_z_s1)
	);

	asd_merge u_merge (
		.clk          (clk),
		.en           (en_s2),
		.sq_x_s1      (sq_x_s1),
		.sq_y_s1      (sq_y_s1),
		.sq_z_s1      (sq_z_s1),
		.ctl_s1       (ctl_s1),
		.threshold_sq (threshold_sq_q),
		.req_s2       (req_s2)
	);

	asd_step_ctrl u_step_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (load_out),
		.req_s2          (req_s2),
		.min_interval_ms (min_interval_ms_q),
		.detected_q      (step_detected),
		.total_q         (step_count)
	);

	assign out_valid = out_valid_q;

	a_clear_zeroes_count: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && (req_s2.op == OP_CLEAR) |=> (step_count == '0) && !step_detected)
		else $error("clear transaction did not zero the step count");

	a_count_follows_flag: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && (req_s2.op == OP_SAMPLE)
		|=> step_count == $past(step_count) + CNT_W'(step_detected))
		else $error("step count does not match the step flag");

	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && out_valid_q)
		else $error("input stalled while the pipeline had room");

endmodule
